// ----- rtl/tch_pkg.sv -----
// Shared constants and the arctangent table for the tilt compensated heading unit.
// No dependencies.
package tch_pkg;

	// guard bits added below each sample
	localparam int GUARD = 6;
	// fraction bits of every angle (degrees)
	localparam int AF = 16;
	// width of the angle accumulators
	localparam int ANG_W = 25;
	// CORDIC gain correction, 1/K scaled by 2^KF
	localparam int KF = 30;
	localparam logic [KF-1:0] KINV = 30'd652032874;
	// entries of the arctangent table
	localparam int TBL_LEN = 24;
	// 90 degrees in angle units
	localparam logic signed [ANG_W-1:0] DEG90 = ANG_W'(90 * (1 << AF));

	// atan(2^-i) in degrees, AF fraction bits
	function automatic logic signed [ANG_W-1:0] atan_deg(input int i);
		logic signed [ANG_W-1:0] r;
		case (i)
			0: r = ANG_W'(2949120);
			1: r = ANG_W'(1740967);
			2: r = ANG_W'(919879);
			3: r = ANG_W'(466945);
			4: r = ANG_W'(234379);
			5: r = ANG_W'(117304);
			6: r = ANG_W'(58666);
			7: r = ANG_W'(29335);
			8: r = ANG_W'(14668);
			9: r = ANG_W'(7334);
			10: r = ANG_W'(3667);
			11: r = ANG_W'(1833);
			12: r = ANG_W'(917);
			13: r = ANG_W'(458);
			14: r = ANG_W'(229);
			15: r = ANG_W'(115);
			16: r = ANG_W'(57);
			17: r = ANG_W'(29);
			18: r = ANG_W'(14);
			19: r = ANG_W'(7);
			20: r = ANG_W'(4);
			21: r = ANG_W'(2);
			22: r = ANG_W'(1);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/tch_rot_cell.sv -----
// One CORDIC micro-rotation cell with registered outputs.
// No dependencies.
module tch_rot_cell #(
	parameter int W = 25,
	parameter int STAGE = 0
) (
	input  logic                clk,
	input  logic signed [W-1:0] x,
	input  logic signed [W-1:0] y,
	input  logic                dir,
	output logic signed [W-1:0] x_rot,
	output logic signed [W-1:0] y_rot
);

	logic signed [W-1:0] x_q, y_q;

	// rotate by +-atan(2^-STAGE) with floor shifts
	always_ff @(posedge clk) begin
		if (dir) begin
			x_q <= x + (y >>> STAGE);
			y_q <= y - (x >>> STAGE);
		end else begin
			x_q <= x - (y >>> STAGE);
			y_q <= y + (x >>> STAGE);
		end
	end

	assign x_rot = x_q;
	assign y_rot = y_q;

endmodule

// ----- rtl/tch_vec_cell.sv -----
// CORDIC vectoring cell: picks its direction from the sign of y and accumulates the angle.
// Depends on tch_pkg and tch_rot_cell.
module tch_vec_cell import tch_pkg::*; #(
	parameter int W = 25,
	parameter int STAGE = 0
) (
	input  logic                    clk,
	input  logic signed [W-1:0]     x,
	input  logic signed [W-1:0]     y,
	input  logic signed [ANG_W-1:0] ang,
	output logic                    dir,
	output logic signed [W-1:0]     x_rot,
	output logic signed [W-1:0]     y_rot,
	output logic signed [ANG_W-1:0] ang_acc
);

	logic signed [ANG_W-1:0] ang_q;

	// drive y toward zero
	assign dir = ~y[W-1];

	tch_rot_cell #(.W(W), .STAGE(STAGE)) u_rot (
		.clk(clk), .x(x), .y(y), .dir(dir), .x_rot(x_rot), .y_rot(y_rot)
	);

	// accumulate the angle turned so far
	always_ff @(posedge clk) begin
		ang_q <= dir ? ang + atan_deg(STAGE) : ang - atan_deg(STAGE);
	end

	assign ang_acc = ang_q;

endmodule

// ----- rtl/tilt_compensated_heading_unit.sv -----
// Top level of the tilt compensated heading unit: four chains of CORDIC cells.
// Depends on tch_pkg, tch_vec_cell and tch_rot_cell.
//
// channel   | handshake      | payload
// ----------+----------------+--------------------------------------------------
// sample in | start / busy   | accel_x accel_y accel_z mag_x mag_y mag_z
// result    | done (strobe)  | pitch_deg roll_deg yaw_deg heading_undefined
//           |                | vector_zero
//
// One sample pair is taken every cycle; busy stays low. Each result passes through
// the four chains of N = min(CORDIC_STAGES, 24) cells (roll, pitch with magnet tilt,
// roll rotation of the magnet, heading) plus five registers for input, gain
// correction of the roll and of the tilted z, setup and output.
// Reset clears the valid bits only; the results are never held back.
module tilt_compensated_heading_unit import tch_pkg::*; #(
	parameter int SAMPLE_BITS = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [SAMPLE_BITS-1:0] accel_x,
	input  logic signed [SAMPLE_BITS-1:0] accel_y,
	input  logic signed [SAMPLE_BITS-1:0] accel_z,
	input  logic signed [SAMPLE_BITS-1:0] mag_x,
	input  logic signed [SAMPLE_BITS-1:0] mag_y,
	input  logic signed [SAMPLE_BITS-1:0] mag_z,
	output logic                          done,
	output logic signed [7:0]             pitch_deg,
	output logic signed [7:0]             roll_deg,
	output logic [8:0]                    yaw_deg,
	output logic                          heading_undefined,
	output logic                          vector_zero
);

	localparam int SB = SAMPLE_BITS;
	localparam int NST = (CORDIC_STAGES < TBL_LEN) ? CORDIC_STAGES : TBL_LEN;
	localparam int W = SB + GUARD + 3;
	localparam int PW = W + KF + 1;
	localparam logic signed [W-1:0] ONE_G = W'(1 << GUARD);

	typedef struct packed {
		logic signed [SB-1:0] ax;
		logic signed [SB-1:0] mx;
		logic signed [SB-1:0] my;
		logic signed [SB-1:0] mz;
		logic                 vz;
		logic                 zr;
		logic [NST-1:0]       dirs;
	} side_a_t;

	typedef struct packed {
		logic signed [SB-1:0] my;
		logic [NST-1:0]       dirs;
		logic signed [7:0]    roll;
		logic                 vz;
	} side_b_t;

	typedef struct packed {
		logic signed [W-1:0] hx;
		logic [NST-1:0]      dirs;
		logic signed [7:0]   pitch;
		logic signed [7:0]   roll;
		logic                vz;
	} side_c_t;

	typedef struct packed {
		logic              undef;
		logic              hxz;
		logic              hxpos;
		logic              hyneg;
		logic signed [7:0] pitch;
		logic signed [7:0] roll;
		logic              vz;
	} side_d_t;

	// clamp to +-90 degrees, truncate toward zero
	function automatic logic signed [7:0] whole_deg(input logic signed [ANG_W-1:0] a);
		logic signed [ANG_W-1:0] c;
		logic signed [ANG_W-1:0] n;
		c = a;
		if (c > DEG90) c = DEG90;
		if (c < -DEG90) c = -DEG90;
		n = -c;
		return c[ANG_W-1] ? -8'(n >>> AF) : 8'(c >>> AF);
	endfunction

	assign busy = 1'b0;

	// ---------------- input register ----------------
	logic                 v_s1;
	logic signed [SB-1:0] ax_s1, ay_s1, az_s1, mx_s1, my_s1, mz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start & ~busy;
	end

	always_ff @(posedge clk) begin
		ax_s1 <= accel_x;
		ay_s1 <= accel_y;
		az_s1 <= accel_z;
		mx_s1 <= mag_x;
		my_s1 <= mag_y;
		mz_s1 <= mag_z;
	end

	// ---------------- roll chain ----------------
	logic signed [W-1:0]     xa [0:NST];
	logic signed [W-1:0]     ya [0:NST];
	logic signed [ANG_W-1:0] aa [0:NST];
	side_a_t                 sa [0:NST];
	logic                    va [0:NST];
	logic                    da [0:NST-1];
	logic signed [W-1:0]     az_abs;

	// set up (|az|, ay) scaled by the guard bits; a zero vector points along +x
	always_comb begin
		az_abs = az_s1[SB-1] ? -W'(az_s1) : W'(az_s1);
		sa[0].ax = ax_s1;
		sa[0].mx = mx_s1;
		sa[0].my = my_s1;
		sa[0].mz = mz_s1;
		sa[0].vz = (ax_s1 == '0 && ay_s1 == '0 && az_s1 == '0) ||
			(mx_s1 == '0 && my_s1 == '0 && mz_s1 == '0);
		sa[0].zr = (az_s1 == '0) && (ay_s1 == '0);
		sa[0].dirs = '0;
		xa[0] = sa[0].zr ? ONE_G : (az_abs <<< GUARD);
		ya[0] = W'(ay_s1) <<< GUARD;
		aa[0] = '0;
	end
	assign va[0] = v_s1;

	for (genvar i = 0; i < NST; i++) begin : g_roll
		side_a_t sa_nxt;

		tch_vec_cell #(.W(W), .STAGE(i)) u_cell (
			.clk(clk), .x(xa[i]), .y(ya[i]), .ang(aa[i]), .dir(da[i]),
			.x_rot(xa[i+1]), .y_rot(ya[i+1]), .ang_acc(aa[i+1])
		);
		// record the direction of this stage
		always_comb begin
			sa_nxt = sa[i];
			sa_nxt.dirs[i] = da[i];
		end
		// carry the sample along
		always_ff @(posedge clk) begin
			sa[i+1] <= sa_nxt;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) va[i+1] <= 1'b0;
			else va[i+1] <= va[i];
		end
	end

	// ---------------- gain correction of the roll magnitude ----------------
	logic signed [PW-1:0] prod_h;
	logic signed [W-1:0]  h_s2;
	side_b_t              sb_s2;
	logic signed [SB-1:0] ax_s2, mx_s2, mz_s2;
	logic                 v_s2;

	assign prod_h = xa[NST] * $signed({1'b0, KINV});

	always_ff @(posedge clk) begin
		h_s2 <= sa[NST].zr ? '0 : prod_h[KF+W-1:KF];
		ax_s2 <= sa[NST].ax;
		mx_s2 <= sa[NST].mx;
		mz_s2 <= sa[NST].mz;
		sb_s2.my <= sa[NST].my;
		sb_s2.dirs <= sa[NST].dirs;
		sb_s2.roll <= whole_deg(aa[NST]);
		sb_s2.vz <= sa[NST].vz;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= va[NST];
	end

	// ---------------- pitch chain with magnet tilt ----------------
	logic signed [W-1:0]     xb [0:NST];
	logic signed [W-1:0]     yb [0:NST];
	logic signed [ANG_W-1:0] ab [0:NST];
	logic signed [W-1:0]     ub [0:NST];
	logic signed [W-1:0]     wb [0:NST];
	side_b_t                 sbp [0:NST];
	logic                    vb [0:NST];
	logic                    db [0:NST-1];

	always_comb begin
		xb[0] = (h_s2 == '0 && ax_s2 == '0) ? ONE_G : h_s2;
		yb[0] = -(W'(ax_s2) <<< GUARD);
		ab[0] = '0;
		ub[0] = W'(mx_s2) <<< GUARD;
		wb[0] = W'(mz_s2) <<< GUARD;
	end
	assign sbp[0] = sb_s2;
	assign vb[0] = v_s2;

	for (genvar i = 0; i < NST; i++) begin : g_pitch
		tch_vec_cell #(.W(W), .STAGE(i)) u_cell (
			.clk(clk), .x(xb[i]), .y(yb[i]), .ang(ab[i]), .dir(db[i]),
			.x_rot(xb[i+1]), .y_rot(yb[i+1]), .ang_acc(ab[i+1])
		);
		// replay the same rotation on (mx, mz)
		tch_rot_cell #(.W(W), .STAGE(i)) u_mag (
			.clk(clk), .x(ub[i]), .y(wb[i]), .dir(db[i]),
			.x_rot(ub[i+1]), .y_rot(wb[i+1])
		);
		always_ff @(posedge clk) begin
			sbp[i+1] <= sbp[i];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vb[i+1] <= 1'b0;
			else vb[i+1] <= vb[i];
		end
	end

	// ---------------- gain correction of the tilted z ----------------
	logic signed [PW-1:0] prod_z;
	logic signed [W-1:0]  mzp_s3;
	logic signed [SB-1:0] my_s3;
	side_c_t              sc_s3;
	logic                 v_s3;

	assign prod_z = wb[NST] * $signed({1'b0, KINV});

	always_ff @(posedge clk) begin
		mzp_s3 <= prod_z[KF+W-1:KF];
		my_s3 <= sbp[NST].my;
		sc_s3.hx <= ub[NST];
		sc_s3.dirs <= sbp[NST].dirs;
		sc_s3.pitch <= whole_deg(ab[NST]);
		sc_s3.roll <= sbp[NST].roll;
		sc_s3.vz <= sbp[NST].vz;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= vb[NST];
	end

	// ---------------- roll rotation of the magnet ----------------
	logic signed [W-1:0] pc [0:NST];
	logic signed [W-1:0] qc [0:NST];
	side_c_t             sc [0:NST];
	logic                vc [0:NST];

	assign pc[0] = W'(my_s3) <<< GUARD;
	assign qc[0] = -mzp_s3;
	assign sc[0] = sc_s3;
	assign vc[0] = v_s3;

	for (genvar i = 0; i < NST; i++) begin : g_tilt
		tch_rot_cell #(.W(W), .STAGE(i)) u_mag (
			.clk(clk), .x(pc[i]), .y(qc[i]), .dir(sc[i].dirs[i]),
			.x_rot(pc[i+1]), .y_rot(qc[i+1])
		);
		always_ff @(posedge clk) begin
			sc[i+1] <= sc[i];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vc[i+1] <= 1'b0;
			else vc[i+1] <= vc[i];
		end
	end

	// ---------------- heading setup ----------------
	logic signed [W-1:0] hx_abs_s4, hy_abs_s4;
	side_d_t             sd_s4;
	logic                v_s4;
	logic signed [W-1:0] hx_c, hy_c;

	assign hx_c = sc[NST].hx;
	assign hy_c = pc[NST];

	always_ff @(posedge clk) begin
		hx_abs_s4 <= hx_c[W-1] ? -hx_c : hx_c;
		hy_abs_s4 <= hy_c[W-1] ? -hy_c : hy_c;
		sd_s4.undef <= (hx_c == '0) && (hy_c == '0);
		sd_s4.hxz <= hx_c == '0;
		sd_s4.hxpos <= !hx_c[W-1] && (hx_c != '0);
		sd_s4.hyneg <= hy_c[W-1];
		sd_s4.pitch <= sc[NST].pitch;
		sd_s4.roll <= sc[NST].roll;
		sd_s4.vz <= sc[NST].vz;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else v_s4 <= vc[NST];
	end

	// ---------------- heading chain ----------------
	logic signed [W-1:0]     xd [0:NST];
	logic signed [W-1:0]     yd [0:NST];
	logic signed [ANG_W-1:0] ad [0:NST];
	side_d_t                 sd [0:NST];
	logic                    vd [0:NST];
	logic                    dd [0:NST-1];

	assign xd[0] = hx_abs_s4;
	assign yd[0] = hy_abs_s4;
	assign ad[0] = '0;
	assign sd[0] = sd_s4;
	assign vd[0] = v_s4;

	for (genvar i = 0; i < NST; i++) begin : g_head
		tch_vec_cell #(.W(W), .STAGE(i)) u_cell (
			.clk(clk), .x(xd[i]), .y(yd[i]), .ang(ad[i]), .dir(dd[i]),
			.x_rot(xd[i+1]), .y_rot(yd[i+1]), .ang_acc(ad[i+1])
		);
		always_ff @(posedge clk) begin
			sd[i+1] <= sd[i];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vd[i+1] <= 1'b0;
			else vd[i+1] <= vd[i];
		end
	end

	// ---------------- quadrant rules ----------------
	logic signed [ANG_W-1:0] a_c;
	logic signed [ANG_W:0]   yfp;
	logic [ANG_W-AF:0]       yint;
	logic [8:0]              yaw_c;

	always_comb begin
		a_c = ad[NST];
		if (a_c[ANG_W-1]) a_c = '0;
		if (a_c > DEG90) a_c = DEG90;
		if (sd[NST].hxpos) begin
			yfp = sd[NST].hyneg ? (ANG_W+1)'(360 * (1 << AF)) - (ANG_W+1)'(a_c)
				: (ANG_W+1)'(a_c);
		end else begin
			yfp = sd[NST].hyneg ? (ANG_W+1)'(180 * (1 << AF)) + (ANG_W+1)'(a_c)
				: (ANG_W+1)'(180 * (1 << AF)) - (ANG_W+1)'(a_c);
		end
		yint = yfp[ANG_W:AF];
		if (sd[NST].undef) yaw_c = 9'd0;
		else if (sd[NST].hxz) yaw_c = sd[NST].hyneg ? 9'd90 : 9'd270;
		else if (yint >= (ANG_W-AF+1)'(360)) yaw_c = 9'd0;
		else yaw_c = yint[8:0];
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= vd[NST];
	end

	always_ff @(posedge clk) begin
		pitch_deg <= sd[NST].pitch;
		roll_deg <= sd[NST].roll;
		yaw_deg <= yaw_c;
		heading_undefined <= sd[NST].undef;
		vector_zero <= sd[NST].vz;
	end

endmodule

// ----- rtl/tch_checker.sv -----
// Port level checks for the tilt compensated heading unit, bound to its top level.
// Depends on tch_pkg and tilt_compensated_heading_unit.
module tch_checker import tch_pkg::*; #(
	parameter int CORDIC_STAGES = 16
) (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic signed [7:0] pitch_deg,
	input logic signed [7:0] roll_deg,
	input logic [8:0]        yaw_deg,
	input logic              heading_undefined
);

	localparam int NST = (CORDIC_STAGES < TBL_LEN) ? CORDIC_STAGES : TBL_LEN;
	localparam int LAT = 4 * NST + 5;

	// every result follows a transfer by the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a matching transfer");

	// an undefined heading reads as zero
	a_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && heading_undefined |-> yaw_deg == 9'd0)
		else $error("undefined heading not zero");

	// heading stays below a full turn
	a_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> yaw_deg < 9'd360)
		else $error("heading out of range");

	// pitch and roll stay within a quarter turn
	a_tilt_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> pitch_deg <= 8'sd90 && pitch_deg >= -8'sd90 &&
			roll_deg <= 8'sd90 && roll_deg >= -8'sd90)
		else $error("tilt angle out of range");

endmodule

bind tilt_compensated_heading_unit tch_checker #(
	.CORDIC_STAGES(CORDIC_STAGES)
) u_tch_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.pitch_deg(pitch_deg),
	.roll_deg(roll_deg),
	.yaw_deg(yaw_deg),
	.heading_undefined(heading_undefined)
);

// ----- bench/testbench.sv -----
// Testbench for tilt_compensated_heading_unit: directed stimulus table, then random sample pairs.
// Expected results come from a local fixed point heading predictor; depends on the RTL only.
`timescale 1ns / 100ps

module testbench;
	localparam int SB = 16;
	localparam int GUARD_BITS = 6;
	localparam int FRAC = 16;
	localparam longint GAIN_INV = 652032874;
	localparam int GAIN_SHIFT = 30;
	localparam int STAGES = 16;
	localparam int LATENCY = 4 * STAGES + 5;
	localparam int RANDOM_ITEMS = 1800;
	localparam int CALM_ITEMS = 200;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic signed [SB-1:0] ax, ay, az, mx, my, mz;
		bit typed;
		logic signed [7:0] pitch, roll;
		logic [8:0] yaw;
		logic undef, vzero;
	} sample_row_t;

	typedef struct {
		logic signed [7:0] pitch, roll;
		logic [8:0] yaw;
		logic undef, vzero;
	} heading_t;

	typedef struct {
		longint mag;
		longint ang;
		int unsigned dirs;
	} vec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [SB-1:0] accel_x = '0, accel_y = '0, accel_z = '0;
	logic signed [SB-1:0] mag_x = '0, mag_y = '0, mag_z = '0;
	logic done;
	logic signed [7:0] pitch_deg, roll_deg;
	logic [8:0] yaw_deg;
	logic heading_undefined, vector_zero;

	// typed expectation travels with the sample it belongs to
	logic row_typed = 1'b0;
	heading_t row_heading = '{default: '0};

	heading_t pending_headings[$];
	int mismatches = 0;
	longint cycles = 0;
	bit idle_on = 1'b1;

	tilt_compensated_heading_unit u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
		.mag_x(mag_x), .mag_y(mag_y), .mag_z(mag_z),
		.done(done), .pitch_deg(pitch_deg), .roll_deg(roll_deg), .yaw_deg(yaw_deg),
		.heading_undefined(heading_undefined), .vector_zero(vector_zero)
	);

	always #5 clk = ~clk;

	function automatic longint atan_step(input int i);
		longint tbl[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
			14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
		return tbl[i];
	endfunction

	// run the vectoring micro-rotations, record each direction
	function automatic vec_t cordic_vector(input longint x0, input longint y0);
		vec_t r;
		longint x, y, dx, dy;
		bit zero;
		x = x0;
		y = y0;
		zero = (x == 0 && y == 0);
		if (zero) x = longint'(1) <<< GUARD_BITS;
		r.ang = 0;
		r.dirs = 0;
		for (int i = 0; i < STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx;
				y -= dy;
				r.ang += atan_step(i);
				r.dirs |= 1 << i;
			end else begin
				x -= dx;
				y += dy;
				r.ang -= atan_step(i);
			end
		end
		r.mag = zero ? 0 : x;
		return r;
	endfunction

	// replay recorded micro-rotations on another vector
	function automatic void cordic_replay(inout longint u, inout longint v,
			input int unsigned dirs);
		longint du, dv;
		for (int i = 0; i < STAGES; i++) begin
			du = v >>> i;
			dv = u >>> i;
			if ((dirs >> i) & 1) begin
				u += du;
				v -= dv;
			end else begin
				u -= du;
				v += dv;
			end
		end
	endfunction

	function automatic longint to_whole_deg(input longint a);
		longint lim;
		lim = longint'(90) <<< FRAC;
		if (a > lim) a = lim;
		if (a < -lim) a = -lim;
		return a >= 0 ? (a >>> FRAC) : -((-a) >>> FRAC);
	endfunction

	function automatic heading_t predict_heading(input sample_row_t s);
		heading_t h;
		longint g, ax, ay, az, mx, my, mz, hm, u, v, mzp, p, q, a, yaw_fp, yaw;
		vec_t roll, pitch, t;
		g = longint'(1) <<< GUARD_BITS;
		ax = s.ax; ay = s.ay; az = s.az;
		mx = s.mx; my = s.my; mz = s.mz;
		h.vzero = (ax == 0 && ay == 0 && az == 0) || (mx == 0 && my == 0 && mz == 0);
		roll = cordic_vector((az < 0 ? -az : az) * g, ay * g);
		hm = (roll.mag * GAIN_INV) >>> GAIN_SHIFT;
		pitch = cordic_vector(hm, -ax * g);
		u = mx * g;
		v = mz * g;
		cordic_replay(u, v, pitch.dirs);
		mzp = (v * GAIN_INV) >>> GAIN_SHIFT;
		p = my * g;
		q = -mzp;
		cordic_replay(p, q, roll.dirs);
		h.undef = 1'b0;
		yaw_fp = 0;
		yaw = 0;
		if (u == 0 && p == 0) begin
			h.undef = 1'b1;
		end else if (u == 0) begin
			yaw_fp = longint'(p < 0 ? 90 : 270) <<< FRAC;
		end else begin
			t = cordic_vector(u < 0 ? -u : u, p < 0 ? -p : p);
			a = t.ang;
			if (a < 0) a = 0;
			if (a > (longint'(90) <<< FRAC)) a = longint'(90) <<< FRAC;
			if (u > 0)
				yaw_fp = p >= 0 ? a : (longint'(360) <<< FRAC) - a;
			else
				yaw_fp = p >= 0 ? (longint'(180) <<< FRAC) - a : (longint'(180) <<< FRAC) + a;
		end
		if (!h.undef) begin
			yaw = yaw_fp >>> FRAC;
			if (yaw >= 360) yaw = 0;
		end
		h.pitch = 8'(to_whole_deg(pitch.ang));
		h.roll = 8'(to_whole_deg(roll.ang));
		h.yaw = 9'(yaw);
		return h;
	endfunction

	// hold one sample pair on the ports until it transfers, with an optional gap first
	task automatic send_sample(input sample_row_t s);
		bit taken;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		start <= 1'b1;
		accel_x <= s.ax; accel_y <= s.ay; accel_z <= s.az;
		mag_x <= s.mx; mag_y <= s.my; mag_z <= s.mz;
		row_typed <= s.typed;
		row_heading <= '{s.pitch, s.roll, s.yaw, s.undef, s.vzero};
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
	endtask

	function automatic logic signed [SB-1:0] pick_axis();
		case ($urandom_range(0, 5))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return '0;
			3: return SB'($signed($urandom_range(0, 4000)) - 2000);
			default: return SB'($urandom);
		endcase
	endfunction

	function automatic sample_row_t random_sample();
		sample_row_t s;
		s = '{default: '0};
		if ($urandom_range(0, 2) == 0) begin
			s.ax = pick_axis(); s.ay = pick_axis(); s.az = pick_axis();
			s.mx = pick_axis(); s.my = pick_axis(); s.mz = pick_axis();
		end else begin
			s.ax = SB'($urandom); s.ay = SB'($urandom); s.az = SB'($urandom);
			s.mx = SB'($urandom); s.my = SB'($urandom); s.mz = SB'($urandom);
		end
		return s;
	endfunction

	// record each transfer and check each result strobe
	always @(posedge clk) begin
		sample_row_t s;
		heading_t want;
		if (arst_n) begin
			if (start && !busy) begin
				s = '{default: '0};
				s.ax = accel_x; s.ay = accel_y; s.az = accel_z;
				s.mx = mag_x; s.my = mag_y; s.mz = mag_z;
				pending_headings.push_back(row_typed ? row_heading : predict_heading(s));
			end
			if (done) begin
				if (pending_headings.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: pitch %0d roll %0d yaw %0d",
							pitch_deg, roll_deg, yaw_deg);
				end else begin
					want = pending_headings.pop_front();
					if (pitch_deg !== want.pitch || roll_deg !== want.roll ||
							yaw_deg !== want.yaw || heading_undefined !== want.undef ||
							vector_zero !== want.vzero) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp p %0d r %0d y %0d u %0b z %0b, got p %0d r %0d y %0d u %0b z %0b",
								want.pitch, want.roll, want.yaw, want.undef, want.vzero,
								pitch_deg, roll_deg, yaw_deg, heading_undefined, vector_zero);
					end
				end
			end
		end
	end

	// stop a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tilt_compensated_heading_unit verification failed");
			$finish;
		end
	end

	initial begin
		sample_row_t rows[$];
		sample_row_t s;
		int drain;
		// typed rows: both vectors zero, magnet zero under a level accel
		rows.push_back('{0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1, 1});
		rows.push_back('{0, 0, 16384, 0, 0, 0, 1, 0, 0, 0, 1, 1});
		// predicted rows: extremes, vertical pitch, untilted magnet, axis headings
		rows.push_back('{0, 0, 0, 100, 0, 0, 0, 0, 0, 0, 0, 0});
		rows.push_back('{16'sh7FFF, 0, 0, 300, 200, -100, 0, 0, 0, 0, 0, 0});
		rows.push_back('{16'sh8000, 0, 0, 300, 200, -100, 0, 0, 0, 0, 0, 0});
		rows.push_back('{0, 16'sh7FFF, 0, 500, -500, 0, 0, 0, 0, 0, 0, 0});
		rows.push_back('{0, 16'sh8000, 0, -500, 500, 0, 0, 0, 0, 0, 0, 0});
		rows.push_back('{0, 0, 16'sh8000, 0, 1000, 0, 0, 0, 0, 0, 0, 0});
		rows.push_back('{0, 0, 16384, 0, -1000, 0, 0, 0, 0, 0, 0, 0});
		rows.push_back('{0, 0, 16384, 1000, 1000, 0, 0, 0, 0, 0, 0, 0});
		rows.push_back('{0, 0, 16384, -1000, 1000, 0, 0, 0, 0, 0, 0, 0});
		rows.push_back('{0, 0, 16384, -1000, -1000, 0, 0, 0, 0, 0, 0, 0});
		rows.push_back('{0, 0, 16384, 1000, -1, 0, 0, 0, 0, 0, 0, 0});
		rows.push_back('{0, 0, 16384, 0, 0, 1000, 0, 0, 0, 0, 0, 0});
		rows.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
			0, 0, 0, 0, 0, 0});
		rows.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
			0, 0, 0, 0, 0, 0});
		rows.push_back('{-1, -1, -1, -1, -1, -1, 0, 0, 0, 0, 0, 0});
		rows.push_back('{1, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0});
		rows.push_back('{4000, -3000, 12000, -200, 150, 400, 0, 0, 0, 0, 0, 0});
		rows.push_back('{-8000, 9000, -10000, 50, -60, 70, 0, 0, 0, 0, 0, 0});

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) send_sample(rows[i]);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			idle_on = n < RANDOM_ITEMS - CALM_ITEMS;
			send_sample(random_sample());
		end
		start <= 1'b0;

		// drain outstanding results, then let the pipe settle
		drain = 0;
		while (pending_headings.size() != 0 && drain < 20 * LATENCY) begin
			@(posedge clk);
			drain++;
		end
		repeat (2 * LATENCY) @(posedge clk);

		if (mismatches == 0 && pending_headings.size() == 0)
			$display("tilt_compensated_heading_unit verification clean");
		else
			$display("tilt_compensated_heading_unit verification failed");
		$finish;
	end
endmodule
